// ===== rtl/stable_record_sorter_by_key_core_macros.svh =====
// Assertion macros shared by the sorter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef STABLE_RECORD_SORTER_BY_KEY_CORE_MACROS_SVH
`define STABLE_RECORD_SORTER_BY_KEY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define SRSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SRSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/srsk_pkg.sv =====
// Types and fixed field widths of the stable record sorter.
// No dependencies; used by the record store and the top level.
`default_nettype none
package srsk_pkg;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned CountW = 6;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic                   side;
    logic [CountW-1:0]      count;
  } rec_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SHIFT   = 6'b000010,
    ST_PLACE   = 6'b000100,
    ST_EMIT_RD = 6'b001000,
    ST_EMIT_LD = 6'b010000,
    ST_EMIT_HD = 6'b100000
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/srsk_store.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on srsk_pkg for the record type.
`default_nettype none
module srsk_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire                  clk_i,
  input  wire                  wr_en_i,
  input  wire [AddrW-1:0]      wr_addr_i,
  input  wire srsk_pkg::rec_t  wr_data_i,
  input  wire [AddrW-1:0]      rd_addr_i,
  output srsk_pkg::rec_t       rd_data_o
);
  srsk_pkg::rec_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/stable_record_sorter_by_key_core.sv =====
// Stable sorter: each record is insertion-sorted into the store on arrival.
// A record goes straight into an empty store; otherwise larger entries move up one
// shifted entry per cycle through the store ports, with input stalled, before the record is placed.
// On the last record the set streams out: each result is read from the store, loaded
// into the output register and held while stalled. Reset clears fill level, overflow
// mark and state; the store contents are left undefined and are never used before written.
`default_nettype none
`include "stable_record_sorter_by_key_core_macros.svh"
module stable_record_sorter_by_key_core #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire signed [15:0]  record_key_i,
  input  wire                record_side_i,
  input  wire [5:0]          record_count_i,
  input  wire                last_record_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [15:0] sorted_key_o,
  output logic               sorted_side_o,
  output logic [5:0]         sorted_count_o,
  output logic               end_of_set_o,
  output logic               overflow_flag_o
);
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  srsk_pkg::state_e state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    k_q, k_d;
  logic             last_q, last_d;
  srsk_pkg::rec_t   rec_q, rec_d;
  srsk_pkg::rec_t   out_q, out_d;
  logic             end_q, end_d;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  srsk_pkg::rec_t   wr_data;
  logic [AW-1:0]    rd_addr;
  srsk_pkg::rec_t   rd_data;
  srsk_pkg::rec_t   in_rec;
  logic             in_acc;
  logic             out_acc;
  logic             full;
  logic             greater;

  srsk_store #(
    .Depth(MAX_RECORDS),
    .AddrW(AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign in_rec.key   = record_key_i;
  assign in_rec.side  = record_side_i;
  assign in_rec.count = record_count_i;

  assign in_stall_o  = (state_q != srsk_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == srsk_pkg::ST_EMIT_HD);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (fill_q == CW'(MAX_RECORDS));
  assign greater     = ($signed(rd_data.key) > $signed(rec_q.key));

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    pos_d   = pos_q;
    k_d     = k_q;
    last_d  = last_q;
    rec_d   = rec_q;
    out_d   = out_q;
    end_d   = end_q;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = rec_q;
    rd_addr = '0;
    case (state_q)
      srsk_pkg::ST_IDLE: begin
        // read the top entry ahead of the first compare
        rd_addr = fill_q[AW-1:0] - AW'(1);
        if (in_acc) begin
          rec_d  = in_rec;
          last_d = last_record_i;
          k_d    = '0;
          if (full) begin
            ovf_d = 1'b1;
            if (last_record_i) begin
              state_d = srsk_pkg::ST_EMIT_RD;
            end
          end else if (fill_q == '0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = in_rec;
            fill_d  = CW'(1);
            if (last_record_i) begin
              state_d = srsk_pkg::ST_EMIT_RD;
            end
          end else begin
            pos_d   = fill_q[AW-1:0];
            state_d = srsk_pkg::ST_SHIFT;
          end
        end
      end
      srsk_pkg::ST_SHIFT: begin
        rd_addr = pos_q - AW'(2);
        wr_en   = 1'b1;
        wr_addr = pos_q;
        if (greater) begin
          // move the larger entry up one slot
          wr_data = rd_data;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = srsk_pkg::ST_PLACE;
          end
        end else begin
          wr_data = rec_q;
          fill_d  = fill_q + CW'(1);
          state_d = last_q ? srsk_pkg::ST_EMIT_RD : srsk_pkg::ST_IDLE;
        end
      end
      srsk_pkg::ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = rec_q;
        fill_d  = fill_q + CW'(1);
        state_d = last_q ? srsk_pkg::ST_EMIT_RD : srsk_pkg::ST_IDLE;
      end
      srsk_pkg::ST_EMIT_RD: begin
        rd_addr = k_q;
        state_d = srsk_pkg::ST_EMIT_LD;
      end
      srsk_pkg::ST_EMIT_LD: begin
        out_d   = rd_data;
        end_d   = ({1'b0, k_q} + (AW+1)'(1)) == (AW+1)'(fill_q);
        state_d = srsk_pkg::ST_EMIT_HD;
      end
      srsk_pkg::ST_EMIT_HD: begin
        rd_addr = k_q + AW'(1);
        if (out_acc) begin
          if (end_q) begin
            // set done: start an empty one
            fill_d  = '0;
            ovf_d   = 1'b0;
            k_d     = '0;
            state_d = srsk_pkg::ST_IDLE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = srsk_pkg::ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_d = srsk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsk_pkg::ST_IDLE;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    out_q <= out_d;
    end_q <= end_d;
  end

  assign sorted_key_o    = out_q.key;
  assign sorted_side_o   = out_q.side;
  assign sorted_count_o  = out_q.count;
  assign end_of_set_o    = end_q;
  assign overflow_flag_o = ovf_q;

  `SRSK_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CW'(MAX_RECORDS), "fill level above capacity")
  `SRSK_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid_o, in_stall_o, "input taken during emission")
  `SRSK_ASSERT_IMP(a_shift_pos, clk_i, rst_ni, state_q == srsk_pkg::ST_SHIFT, pos_q != '0, "shift with no entry below")
  `SRSK_ASSERT_NXT(a_set_clear, clk_i, rst_ni, out_acc && end_q, fill_q == '0 && !ovf_q, "set not cleared after last beat")
  `SRSK_ASSERT_IMP(a_emit_nonempty, clk_i, rst_ni, out_valid_o, fill_q != '0, "emission from empty store")
endmodule
`default_nettype wire
